// ===== hdl/bie_pkg.sv =====
// Shared types and constants for the bytecode instruction encoder.
`default_nettype none

package bie_pkg;

  localparam int unsigned RegW    = 31;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_CODE_BASE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CODE_LENGTH = 2'd1;

  // Opcodes that carry a code target.
  localparam logic [7:0] OP_JUMP         = 8'd28;
  localparam logic [7:0] OP_JUMP_COND    = 8'd29;
  localparam logic [7:0] OP_LOOP         = 8'd30;
  localparam logic [7:0] OP_PUSH_HANDLER = 8'd57;

  // One classified instruction, handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] zz;       // zigzag-mapped operand
    logic [2:0]  ngroups;  // number of LEB128 bytes, 1 to 5
    logic        err;      // code target out of range
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bie_if.sv =====
// Valid/ready channel interfaces for instructions and encoded bytes.
`default_nettype none

interface bie_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        opcode;
  logic signed [31:0] operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface bie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       target_error;

  modport source (output valid, output out_byte, output last, output target_error,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input target_error,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bie_front.sv =====
// Front part: configuration registers, target check, rebasing, zigzag and length.
`default_nettype none

module bie_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bie_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bie_pkg::RegW-1:0]    cfg_wdata_i,
  bie_in_if.sink                           in_ch_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output bie_pkg::cmd_t                    cmd_o
);

  logic [bie_pkg::RegW-1:0] base_q, base_d;
  logic [bie_pkg::RegW-1:0] len_q, len_d;

  always_comb begin
    base_d = base_q;
    len_d  = len_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bie_pkg::REG_CODE_BASE:   base_d = cfg_wdata_i;
        bie_pkg::REG_CODE_LENGTH: len_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      len_q  <= bie_pkg::RegW'(1);
    end else begin
      base_q <= base_d;
      len_q  <= len_d;
    end
  end

  logic               carries;
  logic               check;
  logic signed [33:0] v_s, lo_s, hi_s;
  logic               out_range;
  logic [31:0]        u;
  logic [31:0]        z;
  logic [2:0]         ngroups;

  always_comb begin
    carries = in_ch_i.opcode inside {bie_pkg::OP_JUMP, bie_pkg::OP_JUMP_COND,
                                     bie_pkg::OP_LOOP, bie_pkg::OP_PUSH_HANDLER};
    check     = (base_q != '0) && carries;
    v_s       = {{2{in_ch_i.operand_value[31]}}, in_ch_i.operand_value};
    lo_s      = {3'b000, base_q};
    hi_s      = lo_s + {3'b000, len_q};
    out_range = (v_s < lo_s) || (v_s >= hi_s);
    u = check ? (in_ch_i.operand_value - {1'b0, base_q}) : in_ch_i.operand_value;
    z = {u[30:0], 1'b0} ^ {32{u[31]}};
    if (z[31:28] != '0)      ngroups = 3'd5;
    else if (z[27:21] != '0) ngroups = 3'd4;
    else if (z[20:14] != '0) ngroups = 3'd3;
    else if (z[13:7] != '0)  ngroups = 3'd2;
    else                     ngroups = 3'd1;
  end

  assign in_ch_i.ready = !q_full_i;
  assign push_o        = in_ch_i.valid && !q_full_i;
  assign cmd_o.opcode  = in_ch_i.opcode;
  assign cmd_o.zz      = z;
  assign cmd_o.ngroups = ngroups;
  assign cmd_o.err     = check && out_range;

endmodule

`default_nettype wire

// ===== hdl/bie_fifo.sv =====
// Short queue of classified instructions between the front and back parts.
`default_nettype none

module bie_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  bie_pkg::cmd_t      wdata_i,
  input  wire logic          pop_i,
  output bie_pkg::cmd_t      rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  bie_pkg::cmd_t   mem_q [DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign full_o  = (cnt_q == Full);
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != Full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/bie_back.sv =====
// Back part: serializes the opcode and LEB128 bytes into the output register.
`default_nettype none

module bie_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  bie_pkg::cmd_t cmd_i,
  input  wire logic     empty_i,
  output logic          pop_o,
  bie_out_if.source     out_ch_o
);

  logic        busy_q, busy_d;
  logic [31:0] zz_q, zz_d;
  logic [2:0]  rem_q, rem_d;
  logic        vld_q, vld_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        err_q, err_d;
  logic        adv;
  logic        fin;

  always_comb begin
    adv    = !vld_q || out_ch_o.ready;
    fin    = (rem_q == 3'd1);
    busy_d = busy_q;
    zz_d   = zz_q;
    rem_d  = rem_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    err_d  = err_q;
    pop_o  = 1'b0;
    if (adv) begin
      if (busy_q) begin
        // Next seven-bit group, continuation bit on all but the final one.
        vld_d  = 1'b1;
        byte_d = {!fin, zz_q[6:0]};
        last_d = fin;
        err_d  = 1'b0;
        zz_d   = zz_q >> 7;
        rem_d  = rem_q - 3'd1;
        busy_d = !fin;
      end else if (!empty_i) begin
        pop_o = 1'b1;
        vld_d = 1'b1;
        if (cmd_i.err) begin
          byte_d = '0;
          last_d = 1'b1;
          err_d  = 1'b1;
        end else begin
          byte_d = cmd_i.opcode;
          last_d = 1'b0;
          err_d  = 1'b0;
          zz_d   = cmd_i.zz;
          rem_d  = cmd_i.ngroups;
          busy_d = 1'b1;
        end
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      vld_q  <= vld_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zz_q   <= zz_d;
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign out_ch_o.valid        = vld_q;
  assign out_ch_o.out_byte     = byte_q;
  assign out_ch_o.last         = last_q;
  assign out_ch_o.target_error = err_q;

  a_busy_has_groups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0) && (rem_q <= 3'd5))
    else $error("serializer busy without groups left");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && err_q) |-> last_q)
    else $error("error result not marked last");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q)
    else $error("new instruction taken while serializing");

endmodule

`default_nettype wire

// ===== hdl/bytecode_instruction_encoder_core.sv =====
// Top level of the bytecode instruction encoder: zigzag plus LEB128 byte stream.
//
// Instructions enter on in_ch_i (opcode and signed 32-bit operand); encoded bytes
// leave on out_ch_o, one byte per transfer. A byte stream for one instruction is
// the opcode followed by one to five LEB128 bytes, the final one flagged last. A
// jump-type target outside the configured code range yields one transfer with
// target_error and last set, and no other bytes.
// The front part checks and rebases the target, zigzag-maps the operand and counts
// its groups in the cycle it is accepted, and writes a queue of FIFO_DEPTH entries.
// The back part pops one entry and sends one byte per cycle from an output register
// while the receiver is ready, so an instruction occupies the output for 2 to 6 bytes
// (1 for an error); that byte-wide output is what sets the throughput. An accepted
// instruction is written into the queue, and its first byte is then loaded into the
// output register. The next instruction is popped as the previous final byte leaves
// the output register, so the byte stream has no gaps while the queue holds entries.
// When the receiver stalls, the output register holds its byte; the queue then
// fills and in_ch_i.ready drops. Reset empties the queue and output register, and
// sets the base register to 0 (checking off) and the length register to 1.
// Configuration writes take effect at the clock edge where cfg_we_i is high.
`default_nettype none

module bytecode_instruction_encoder_core #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bie_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bie_pkg::RegW-1:0]    cfg_wdata_i,
  bie_in_if.sink                           in_ch_i,
  bie_out_if.source                        out_ch_o
);

  // Queue between the classifying front and the serializing back.
  bie_pkg::cmd_t push_cmd;
  bie_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  bie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch_i     (in_ch_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  bie_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back part owns the output register; it pops only when that register frees.
  bie_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (head_cmd),
    .empty_i  (q_empty),
    .pop_o    (pop),
    .out_ch_o (out_ch_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_bytecode_instruction_encoder_core.sv =====
// Self-checking testbench for the bytecode instruction encoder core.
`timescale 1ns / 100ps

module tb_bytecode_instruction_encoder_core;

  // Timing of the bench. The watchdog limit counts cycles without any transfer;
  // the slowest legal stretch is an idle gap plus the path through queue and output register.
  localparam int unsigned HalfPeriod     = 6;
  localparam int unsigned ResetCycles    = 3;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned ItemsPerPhase  = 48;
  localparam logic [bie_pkg::RegW-1:0] RegMax = {bie_pkg::RegW{1'b1}};

  // A register index that the block does not decode; writes to it are dropped.
  localparam logic [bie_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;

  // One encoded byte as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       target_error;
  } enc_byte_t;

  // Predicts the byte stream of every accepted instruction and holds the bytes
  // still owed by the block, oldest first.
  class encoder_scoreboard;
    logic [bie_pkg::RegW-1:0] base_reg;
    logic [bie_pkg::RegW-1:0] code_length;
    enc_byte_t                owed_bytes[$];

    function new();
      base_reg    = '0;
      code_length = bie_pkg::RegW'(1);
    endfunction

    function void set_register(logic [bie_pkg::CfgIdxW-1:0] idx,
                               logic [bie_pkg::RegW-1:0] data);
      if (idx == bie_pkg::REG_CODE_BASE) begin
        base_reg = data;
      end else if (idx == bie_pkg::REG_CODE_LENGTH) begin
        code_length = data;
      end
    endfunction

    function bit is_target_op(logic [7:0] op);
      return op inside {bie_pkg::OP_JUMP, bie_pkg::OP_JUMP_COND, bie_pkg::OP_LOOP,
                        bie_pkg::OP_PUSH_HANDLER};
    endfunction

    function void note_instruction(logic [7:0] op, logic signed [31:0] operand);
      longint    lo;
      longint    hi;
      longint    v;
      logic [31:0] u;
      logic [31:0] zz;
      enc_byte_t b;
      v = operand;
      if (base_reg != '0 && is_target_op(op)) begin
        // The upper bound is formed in 64 bits, so it never wraps.
        lo = base_reg;
        hi = lo + longint'(code_length);
        if (v < lo || v >= hi) begin
          b.out_byte     = 8'h00;
          b.last         = 1'b1;
          b.target_error = 1'b1;
          owed_bytes.push_back(b);
          return;
        end
        v = v - lo;
      end
      u  = v[31:0];
      zz = (u << 1) ^ {32{u[31]}};
      b.out_byte     = op;
      b.last         = 1'b0;
      b.target_error = 1'b0;
      owed_bytes.push_back(b);
      do begin
        b.out_byte = {1'b0, zz[6:0]};
        zz         = zz >> 7;
        b.last     = (zz == 32'd0);
        if (!b.last) begin
          b.out_byte[7] = 1'b1;
        end
        owed_bytes.push_back(b);
      end while (zz != 32'd0);
    endfunction

    // Returns an empty string when the byte matches the oldest owed byte.
    function string check_byte(logic [7:0] out_byte, logic last, logic target_error);
      enc_byte_t want;
      if (owed_bytes.size() == 0) begin
        return $sformatf("unexpected byte %02h last=%0b err=%0b",
                         out_byte, last, target_error);
      end
      want = owed_bytes.pop_front();
      if (want.out_byte !== out_byte || want.last !== last ||
          want.target_error !== target_error) begin
        return $sformatf("byte %02h last=%0b err=%0b, wanted %02h last=%0b err=%0b",
                         out_byte, last, target_error,
                         want.out_byte, want.last, want.target_error);
      end
      return "";
    endfunction

    function int outstanding();
      return owed_bytes.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [bie_pkg::CfgIdxW-1:0] cfg_idx;
  logic [bie_pkg::RegW-1:0] cfg_wdata;

  // Idling on both channels is switched off for the final part of the run.
  bit              idle_en;
  int unsigned     mismatches;
  int unsigned     quiet_cycles;
  encoder_scoreboard sb;

  bie_in_if  in_ch ();
  bie_out_if out_ch ();

  bytecode_instruction_encoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch_i     (in_ch),
    .out_ch_o    (out_ch)
  );

  always #HalfPeriod clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one instruction, optionally after a short gap, and returns at the
  // rising edge where the transfer happens. Valid stays high on return, so a
  // following call can present its item at the next falling edge without a dip.
  task automatic send_instr(input logic [7:0] op, input logic [31:0] val);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.opcode        = op;
    in_ch.operand_value = val;
    in_ch.valid         = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    sb.note_instruction(op, val);
  endtask

  // Stops offering input and waits until every owed byte has been seen, then
  // lets the block settle so that it is surely idle.
  task automatic drain_and_settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // A register write lasts one cycle; the block takes it at the rising edge.
  task automatic write_reg(input logic [bie_pkg::CfgIdxW-1:0] idx,
                           input logic [bie_pkg::RegW-1:0] data);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic configure(input logic [bie_pkg::RegW-1:0] base,
                           input logic [bie_pkg::RegW-1:0] len);
    drain_and_settle();
    write_reg(bie_pkg::REG_CODE_BASE, base);
    write_reg(bie_pkg::REG_CODE_LENGTH, len);
  endtask

  // Picks a register setting, favoring the corners: checking off, an empty range,
  // a single target, and the largest base and length.
  task automatic random_config();
    logic [bie_pkg::RegW-1:0] base;
    logic [bie_pkg::RegW-1:0] len;
    case ($urandom_range(0, 4))
      0:       base = '0;
      1:       base = bie_pkg::RegW'($urandom_range(1, 255));
      2:       base = bie_pkg::RegW'($urandom);
      3:       base = RegMax;
      default: base = bie_pkg::RegW'($urandom_range(1, 100000));
    endcase
    case ($urandom_range(0, 4))
      0:       len = '0;
      1:       len = bie_pkg::RegW'(1);
      2:       len = bie_pkg::RegW'($urandom_range(1, 300));
      3:       len = RegMax;
      default: len = bie_pkg::RegW'($urandom);
    endcase
    configure(base, len);
  endtask

  // Four opcodes in ten carry a code target; half the operands lie inside or just around
  // the valid range, so the rebasing path is well exercised, and the rest are arbitrary.
  task automatic random_phase(input int unsigned count);
    logic [7:0]  op;
    logic [31:0] r;
    longint      base_l;
    longint      len_l;
    longint      rl;
    longint      target;
    for (int unsigned i = 0; i < count; i++) begin
      base_l = sb.base_reg;
      len_l  = sb.code_length;
      r      = $urandom;
      rl     = r;
      case ($urandom_range(0, 9))
        0:       op = bie_pkg::OP_JUMP;
        1:       op = bie_pkg::OP_JUMP_COND;
        2:       op = bie_pkg::OP_LOOP;
        3:       op = bie_pkg::OP_PUSH_HANDLER;
        default: op = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0: target = base_l + ((len_l == 0) ? 0 : rl % len_l);
        1: target = base_l + len_l + $signed($urandom_range(0, 3)) - 2;
        2: begin
          target = rl >> $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) begin
            target = -target;
          end
        end
        default: target = rl;
      endcase
      send_instr(op, target[31:0]);
    end
  endtask

  // Output side: while idling is enabled, the receiver stalls in bursts of random length
  // and is otherwise ready for stretches of varying length.
  initial begin : ready_gen
    int unsigned n;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        n = $urandom_range(1, 5);
      end else begin
        out_ch.ready = 1'b1;
        n = $urandom_range(1, 8);
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  // Every output transfer is checked against the oldest owed byte.
  always @(posedge clk_i) begin : byte_monitor
    string msg;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      msg = sb.check_byte(out_ch.out_byte, out_ch.last, out_ch.target_error);
      if (msg != "") begin
        report_mismatch(msg);
      end
    end
  end

  // The watchdog ends a run that has stopped making progress on both channels.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = bie_pkg::REG_CODE_BASE;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = 8'h00;
    in_ch.operand_value = 32'sd0;
    idle_en             = 1'b1;
    mismatches          = 0;
    quiet_cycles        = 0;
    sb                  = new();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset state: checking is off, so code targets pass through unchanged.
    // The operands cover zero, both extremes and the group boundaries.
    send_instr(8'd0,                     32'd0);
    send_instr(8'd255,                   32'hFFFF_FFFF);
    send_instr(bie_pkg::OP_JUMP,         32'h7FFF_FFFF);
    send_instr(bie_pkg::OP_PUSH_HANDLER, 32'h8000_0000);
    send_instr(8'd1,                     32'd63);
    send_instr(8'd2,                     32'd64);
    send_instr(8'd3,                     -32'sd64);
    send_instr(8'd4,                     -32'sd65);
    send_instr(8'd200,                   32'd8192);

    // A small window: both bounds, one below, one past the end, a negative
    // target, and an ordinary opcode whose operand is outside the window.
    configure(bie_pkg::RegW'(100), bie_pkg::RegW'(50));
    send_instr(bie_pkg::OP_JUMP,         32'd100);
    send_instr(bie_pkg::OP_JUMP_COND,    32'd149);
    send_instr(bie_pkg::OP_LOOP,         32'd99);
    send_instr(bie_pkg::OP_PUSH_HANDLER, 32'd150);
    send_instr(bie_pkg::OP_JUMP_COND,    -32'sd5);
    send_instr(8'd7,                     32'd5000);

    // Largest base and length: the upper bound lies far beyond any operand.
    configure(RegMax, RegMax);
    send_instr(bie_pkg::OP_JUMP,         32'h7FFF_FFFF);
    send_instr(bie_pkg::OP_PUSH_HANDLER, 32'hFFFF_FFFF);
    send_instr(bie_pkg::OP_LOOP,         32'h8000_0000);

    // An empty range rejects every target; the write to a spare index must not
    // disturb the setting.
    configure(bie_pkg::RegW'(5), '0);
    write_reg(REG_SPARE, RegMax);
    send_instr(bie_pkg::OP_JUMP,         32'd5);
    send_instr(bie_pkg::OP_JUMP_COND,    32'd4);
    send_instr(8'd0,                     32'd5);

    // Smallest nonzero base with the largest length: every positive target fits.
    configure(bie_pkg::RegW'(1), RegMax);
    send_instr(bie_pkg::OP_LOOP,         32'h7FFF_FFFF);
    send_instr(bie_pkg::OP_JUMP,         32'd1);
    send_instr(bie_pkg::OP_JUMP_COND,    32'd0);

    // Random part: a new register setting for every phase, and no idling on
    // either side during the last one.
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      random_config();
      if (p == RandomPhases - 1) begin
        idle_en = 1'b0;
      end
      random_phase(ItemsPerPhase);
    end

    drain_and_settle();
    if (mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bie_pkg.sv
hdl/bie_if.sv
hdl/bie_front.sv
hdl/bie_fifo.sv
hdl/bie_back.sv
hdl/bytecode_instruction_encoder_core.sv
verif/tb_bytecode_instruction_encoder_core.sv
